// ===== rtl/tcbst_pkg.sv =====
// ----------------------------------------------------------------------------
// tcbst_pkg: shared types and constants of the TCB spline tangent stream
// Field widths, fixed-point formats, mode codes and the output clamp.
// ----------------------------------------------------------------------------
package tcbst_pkg;

    // Coordinate and register formats
    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 14;
    localparam int REG_WIDTH   = 16;
    localparam int REG_FRAC    = 14;
    localparam int OUT_WIDTH   = 21;
    localparam int NUM_LANES   = 3;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TENSION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTINUITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS       = 2'd2;

    // Weight arithmetic: three (1 +- x) factors of REG_WIDTH+1 bits
    localparam int FACT_W  = REG_WIDTH + 1;
    localparam int P1_W    = 2 * FACT_W;
    localparam int P2_W    = P1_W + FACT_W;
    localparam int W_SHIFT = 3 * REG_FRAC + 1 - FRAC_BITS;
    localparam int WGT_W   = P2_W - W_SHIFT + 1;

    // Lane arithmetic
    localparam int CHORD_W = COORD_WIDTH + 1;
    localparam int PROD_W  = CHORD_W + WGT_W;
    localparam int RND_W   = PROD_W - FRAC_BITS + 1;
    localparam int SUM_W   = RND_W + 1;
    localparam int EXT_A   = (SUM_W > CHORD_W) ? SUM_W : CHORD_W;
    localparam int EXT_W   = (EXT_A > OUT_WIDTH) ? EXT_A : OUT_WIDTH;

    // How a tangent is formed
    localparam logic [1:0] MODE_ZERO     = 2'd0;
    localparam logic [1:0] MODE_CHORD    = 2'd1;
    localparam logic [1:0] MODE_WEIGHTED = 2'd2;

    typedef struct packed {
        logic [WGT_W-1:0] wa;
        logic [WGT_W-1:0] wb;
    } t_weights;

    typedef struct packed {
        logic       adv;
        logic       upd_newer;
        logic       upd_older;
        logic [1:0] mode;
    } t_lane_ctl;

    function automatic logic [OUT_WIDTH-1:0] sat_out(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        hi = EXT_W'((64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1);
        lo = EXT_W'(-(64'sd1 <<< (OUT_WIDTH - 1)));
        if (v > hi) begin
            return hi[OUT_WIDTH-1:0];
        end else if (v < lo) begin
            return lo[OUT_WIDTH-1:0];
        end
        return v[OUT_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/tcb_spline_tangent_stream_unit.sv =====
// ----------------------------------------------------------------------------
// tcb_spline_tangent_stream_unit: Kochanek-Bartels tangent stream
// A result passes the control stages, in step with the lane pipes, and then
// the output register; one point is taken every cycle while the output flows.
// The final point of a curve of two or more points yields two transfers and
// holds the input back during the first. Weights come from a 3-stage unit.
// Reset (sync, active low) clears config registers, point count and valids.
// ----------------------------------------------------------------------------
module tcb_spline_tangent_stream_unit (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // configuration write port
    input  logic                                       i_cfg_wr_en,
    input  logic        [tcbst_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic        [tcbst_pkg::REG_WIDTH-1:0]     i_cfg_data,
    // point channel
    input  logic                                       i_valid,
    output logic                                       o_stall,
    input  logic signed [tcbst_pkg::COORD_WIDTH-1:0]   i_point_x,
    input  logic signed [tcbst_pkg::COORD_WIDTH-1:0]   i_point_y,
    input  logic signed [tcbst_pkg::COORD_WIDTH-1:0]   i_point_z,
    input  logic                                       i_last_point,
    // tangent channel
    output logic                                       o_valid,
    input  logic                                       i_stall,
    output logic signed [tcbst_pkg::OUT_WIDTH-1:0]     o_tangent_x,
    output logic signed [tcbst_pkg::OUT_WIDTH-1:0]     o_tangent_y,
    output logic signed [tcbst_pkg::OUT_WIDTH-1:0]     o_tangent_z,
    output logic                                       o_last_tangent
);

    localparam int NL = tcbst_pkg::NUM_LANES;
    localparam int CW = tcbst_pkg::COORD_WIDTH;
    localparam int OW = tcbst_pkg::OUT_WIDTH;
    localparam int NS = 4;   // control stages in step with the lanes

    // points seen in the current curve
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    // Configuration registers
    logic signed [tcbst_pkg::REG_WIDTH-1:0] r_tension;
    logic signed [tcbst_pkg::REG_WIDTH-1:0] r_continuity;
    logic signed [tcbst_pkg::REG_WIDTH-1:0] r_bias_amount;

    logic [1:0] r_seen;
    logic [1:0] n_seen;
    logic [1:0] w_mode;
    logic       w_adv;
    logic       w_accept;
    logic       w_item;

    logic       r_stg_v    [NS];
    logic [1:0] r_stg_mode [NS];
    logic       r_stg_last [NS];

    logic                r_out_valid;
    logic                r_out_dup;
    logic                r_out_last;
    logic [OW-1:0]       r_tan [NL];
    logic [OW-1:0]       w_lane_tan [NL];
    logic signed [CW-1:0] w_point [NL];

    tcbst_pkg::t_weights  w_wgt;
    tcbst_pkg::t_lane_ctl w_ctl;

    // ------------------------------------------------------------------
    // Configuration: writes to an index beyond the list are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tension     <= '0;
            r_continuity  <= '0;
            r_bias_amount <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                tcbst_pkg::REG_TENSION:    r_tension     <= i_cfg_data;
                tcbst_pkg::REG_CONTINUITY: r_continuity  <= i_cfg_data;
                tcbst_pkg::REG_BIAS:       r_bias_amount <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tcbst_weight u_weight (
        .i_clk        (i_clk),
        .i_tension    (r_tension),
        .i_continuity (r_continuity),
        .i_bias       (r_bias_amount),
        .o_wgt        (w_wgt)
    );

    // ------------------------------------------------------------------
    // Flow control: the whole pipe advances together when the output
    // register can take a new tangent. A pending copy (last tangent of
    // the curve) holds the pipe for one transfer.
    // ------------------------------------------------------------------
    assign w_adv    = !r_out_valid || (!i_stall && !r_out_dup);
    assign o_stall  = !w_adv;
    assign w_accept = i_valid && w_adv;

    // A point produces a tangent unless it opens a curve of several points
    assign w_item = w_accept && ((r_seen != SEEN_NONE) || i_last_point);

    always_comb begin
        unique case (r_seen)
            SEEN_ONE: w_mode = tcbst_pkg::MODE_CHORD;
            SEEN_TWO: w_mode = tcbst_pkg::MODE_WEIGHTED;
            default:  w_mode = tcbst_pkg::MODE_ZERO;
        endcase
    end

    always_comb begin
        n_seen = r_seen;
        if (w_accept) begin
            if (i_last_point) begin
                n_seen = SEEN_NONE;
            end else if (r_seen == SEEN_NONE) begin
                n_seen = SEEN_ONE;
            end else begin
                n_seen = SEEN_TWO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= SEEN_NONE;
        end else begin
            r_seen <= n_seen;
        end
    end

    // ------------------------------------------------------------------
    // Control stages travel alongside the lane pipes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_stg_v[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_stg_v[0] <= w_item;
            for (int s = 1; s < NS; s++) begin
                r_stg_v[s] <= r_stg_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_stg_mode[0] <= w_mode;
            r_stg_last[0] <= i_last_point;
            for (int s = 1; s < NS; s++) begin
                r_stg_mode[s] <= r_stg_mode[s-1];
                r_stg_last[s] <= r_stg_last[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Lanes: one per coordinate, sharing the weights and the control
    // ------------------------------------------------------------------
    assign w_ctl.adv       = w_adv;
    assign w_ctl.upd_newer = w_accept && !i_last_point;
    assign w_ctl.upd_older = w_accept && !i_last_point && (r_seen != SEEN_NONE);
    assign w_ctl.mode      = r_stg_mode[NS-1];

    assign w_point[0] = i_point_x;
    assign w_point[1] = i_point_y;
    assign w_point[2] = i_point_z;

    for (genvar g = 0; g < NL; g++) begin : g_lane
        tcbst_lane u_lane (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_wgt     (w_wgt),
            .i_point   (w_point[g]),
            .o_tangent (w_lane_tan[g])
        );
    end

    // ------------------------------------------------------------------
    // Merge: gather the three components into the output register. An
    // item closing a curve of two or more points gives its tangent once
    // unmarked, then again marked as last after that transfer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_dup   <= 1'b0;
            r_out_last  <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_stg_v[NS-1];
            r_out_dup   <= r_stg_v[NS-1] && r_stg_last[NS-1]
                           && (r_stg_mode[NS-1] != tcbst_pkg::MODE_ZERO);
            r_out_last  <= (r_stg_mode[NS-1] == tcbst_pkg::MODE_ZERO);
        end else if (!i_stall && r_out_dup) begin
            r_out_dup  <= 1'b0;
            r_out_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < NL; l++) begin
                r_tan[l] <= w_lane_tan[l];
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_last_tangent = r_out_last;
    assign o_tangent_x    = r_tan[0];
    assign o_tangent_y    = r_tan[1];
    assign o_tangent_z    = r_tan[2];

endmodule

// ===== rtl/tcbst_weight.sv =====
// ----------------------------------------------------------------------------
// tcbst_weight: TCB weight unit
// Free-running three-stage pipe forming the incoming and outgoing weights
// from tension, continuity and bias, rounded to FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module tcbst_weight (
    input  logic                                   i_clk,
    input  logic signed [tcbst_pkg::REG_WIDTH-1:0] i_tension,
    input  logic signed [tcbst_pkg::REG_WIDTH-1:0] i_continuity,
    input  logic signed [tcbst_pkg::REG_WIDTH-1:0] i_bias,
    output tcbst_pkg::t_weights                    o_wgt
);

    localparam int FW = tcbst_pkg::FACT_W;
    localparam int P1 = tcbst_pkg::P1_W;
    localparam int P2 = tcbst_pkg::P2_W;
    localparam int SH = tcbst_pkg::W_SHIFT;
    localparam logic signed [FW-1:0] ONE = FW'(1) <<< tcbst_pkg::REG_FRAC;
    localparam logic [P2:0] HALF = (P2 + 1)'(1) << (SH - 1);

    logic signed [FW-1:0] w_t_one;
    logic signed [FW-1:0] w_c_pos;
    logic signed [FW-1:0] w_c_neg;
    logic signed [FW-1:0] w_b_pos;
    logic signed [FW-1:0] w_b_neg;

    logic signed [P1-1:0] r_p1a;
    logic signed [P1-1:0] r_p1b;
    logic signed [FW-1:0] r_b_pos;
    logic signed [FW-1:0] r_b_neg;
    logic signed [P2-1:0] r_p2a;
    logic signed [P2-1:0] r_p2b;
    logic        [P2:0]   w_rnd_a;
    logic        [P2:0]   w_rnd_b;
    tcbst_pkg::t_weights  r_wgt;

    // (1 - t), (1 +- c), (1 +- b)
    assign w_t_one = ONE - FW'(i_tension);
    assign w_c_pos = ONE + FW'(i_continuity);
    assign w_c_neg = ONE - FW'(i_continuity);
    assign w_b_pos = ONE + FW'(i_bias);
    assign w_b_neg = ONE - FW'(i_bias);

    always_ff @(posedge i_clk) begin
        r_p1a   <= w_t_one * w_c_pos;
        r_p1b   <= w_t_one * w_c_neg;
        r_b_pos <= w_b_pos;
        r_b_neg <= w_b_neg;
    end

    always_ff @(posedge i_clk) begin
        r_p2a <= r_p1a * r_b_pos;
        r_p2b <= r_p1b * r_b_neg;
    end

    // Round to nearest, ties upward; the 0.5 factor sits in the shift
    assign w_rnd_a = {r_p2a[P2-1], r_p2a} + HALF;
    assign w_rnd_b = {r_p2b[P2-1], r_p2b} + HALF;

    always_ff @(posedge i_clk) begin
        r_wgt.wa <= w_rnd_a[P2:SH];
        r_wgt.wb <= w_rnd_b[P2:SH];
    end

    assign o_wgt = r_wgt;

endmodule

// ===== rtl/tcbst_lane.sv =====
// ----------------------------------------------------------------------------
// tcbst_lane: one coordinate lane
// Holds the two previous coordinates, forms both chords, weights them and
// delivers the clamped tangent component of the item in its last stage.
// ----------------------------------------------------------------------------
module tcbst_lane (
    input  logic                                      i_clk,
    input  tcbst_pkg::t_lane_ctl                      i_ctl,
    input  tcbst_pkg::t_weights                       i_wgt,
    input  logic signed [tcbst_pkg::COORD_WIDTH-1:0]  i_point,
    output logic        [tcbst_pkg::OUT_WIDTH-1:0]    o_tangent
);

    localparam int CW  = tcbst_pkg::COORD_WIDTH;
    localparam int DW  = tcbst_pkg::CHORD_W;
    localparam int PW  = tcbst_pkg::PROD_W;
    localparam int RW  = tcbst_pkg::RND_W;
    localparam int SW  = tcbst_pkg::SUM_W;
    localparam int EW  = tcbst_pkg::EXT_W;
    localparam int FB  = tcbst_pkg::FRAC_BITS;
    localparam logic [PW:0] HALF = (PW + 1)'(1) << (FB - 1);

    logic signed [CW-1:0] r_newer;
    logic signed [CW-1:0] r_older;
    logic signed [DW-1:0] w_din;
    logic signed [DW-1:0] w_dout;

    logic signed [DW-1:0] r_din  [3];
    logic signed [DW-1:0] r_dout [3];
    logic signed [PW-1:0] r_pa;
    logic signed [PW-1:0] r_pb;
    logic signed [DW-1:0] r_dout4;

    logic        [PW:0]   w_rnd_a;
    logic        [PW:0]   w_rnd_b;
    logic signed [RW-1:0] w_ra;
    logic signed [RW-1:0] w_rb;
    logic signed [SW-1:0] w_sum;
    logic signed [EW-1:0] w_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd_older) begin
            r_older <= r_newer;
        end
        if (i_ctl.upd_newer) begin
            r_newer <= i_point;
        end
    end

    assign w_din  = DW'(r_newer) - DW'(r_older);
    assign w_dout = DW'(i_point) - DW'(r_newer);

    // Chords wait two stages for the weights of the current registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_din[0]  <= w_din;
            r_dout[0] <= w_dout;
            r_din[1]  <= r_din[0];
            r_dout[1] <= r_dout[0];
            r_din[2]  <= r_din[1];
            r_dout[2] <= r_dout[1];
            r_pa      <= r_din[2] * $signed(i_wgt.wa);
            r_pb      <= r_dout[2] * $signed(i_wgt.wb);
            r_dout4   <= r_dout[2];
        end
    end

    assign w_rnd_a = {r_pa[PW-1], r_pa} + HALF;
    assign w_rnd_b = {r_pb[PW-1], r_pb} + HALF;
    assign w_ra    = $signed(w_rnd_a[PW:FB]);
    assign w_rb    = $signed(w_rnd_b[PW:FB]);
    assign w_sum   = SW'(w_ra) + SW'(w_rb);

    always_comb begin
        unique case (i_ctl.mode)
            tcbst_pkg::MODE_CHORD:    w_ext = EW'(r_dout4);
            tcbst_pkg::MODE_WEIGHTED: w_ext = EW'(w_sum);
            default:                  w_ext = '0;
        endcase
    end

    assign o_tangent = tcbst_pkg::sat_out(w_ext);

endmodule
